>>> design/assert_macros.svh
// Assertion macros shared by the next greater element RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");
// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> design/nge_pkg.sv
// Types and constants shared by the next greater element block.
`default_nettype none

package nge_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int POS_W       = 5;
    localparam int MAX_LEN_DEF = 32;

    // One input word: a sequence value and the end-of-sequence flag.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       final_item;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic        [POS_W-1:0]    position;
        logic signed [SAMPLE_W-1:0] greater_value;
        logic                       found;
        logic                       overflow;
        logic                       run_end;
    } out_word_t;

    // One entry of the pending stack.
    typedef struct packed {
        logic        [POS_W-1:0]    position;
        logic signed [SAMPLE_W-1:0] value;
    } stack_entry_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OVF_EMIT,
        ST_POP_READ,
        ST_POP_CMP,
        ST_PUSH,
        ST_FLUSH_READ,
        ST_FLUSH_EMIT
    } nge_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic rd_issue;
        logic pop_emit;
        logic push;
        logic flush_emit;
        logic ovf_emit;
    } nge_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seq_full;
        logic stack_empty;
        logic count_one;
        logic greater;
        logic last;
        logic out_free;
    } nge_status_t;

endpackage

`default_nettype wire

>>> design/nge_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module nge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/nge_ctrl.sv
// Controller state machine for the next greater element block.
`default_nettype none

module nge_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    input  logic                 sample_final,
    input  nge_pkg::nge_status_t status,
    output nge_pkg::nge_cmd_t    cmd,
    output logic                 sample_stall
);

    nge_pkg::nge_state_t state_reg;
    nge_pkg::nge_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nge_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nge_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    if (status.seq_full && !sample_final)
                    begin
                        state_next = nge_pkg::ST_OVF_EMIT;
                    end
                    else if (status.seq_full)
                    begin
                        state_next = nge_pkg::ST_FLUSH_READ;
                    end
                    else
                    begin
                        state_next = nge_pkg::ST_POP_READ;
                    end
                end
            end
            nge_pkg::ST_OVF_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = nge_pkg::ST_IDLE;
                end
            end
            nge_pkg::ST_POP_READ:
            begin
                state_next = status.stack_empty ? nge_pkg::ST_PUSH : nge_pkg::ST_POP_CMP;
            end
            nge_pkg::ST_POP_CMP:
            begin
                if (!status.greater)
                begin
                    state_next = nge_pkg::ST_PUSH;
                end
                else if (status.out_free)
                begin
                    state_next = nge_pkg::ST_POP_READ;
                end
            end
            nge_pkg::ST_PUSH:
            begin
                state_next = status.last ? nge_pkg::ST_FLUSH_READ : nge_pkg::ST_IDLE;
            end
            nge_pkg::ST_FLUSH_READ:
            begin
                state_next = nge_pkg::ST_FLUSH_EMIT;
            end
            nge_pkg::ST_FLUSH_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.count_one ? nge_pkg::ST_IDLE
                                                  : nge_pkg::ST_FLUSH_READ;
                end
            end
            default:
            begin
                state_next = nge_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd          = '0;
        sample_stall = 1'b1;
        unique case (state_reg)
            nge_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                cmd.latch    = sample_valid;
            end
            nge_pkg::ST_OVF_EMIT:
            begin
                cmd.ovf_emit = status.out_free;
            end
            nge_pkg::ST_POP_READ:
            begin
                cmd.rd_issue = !status.stack_empty;
            end
            nge_pkg::ST_POP_CMP:
            begin
                cmd.pop_emit = status.greater && status.out_free;
            end
            nge_pkg::ST_PUSH:
            begin
                cmd.push = 1'b1;
            end
            nge_pkg::ST_FLUSH_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            nge_pkg::ST_FLUSH_EMIT:
            begin
                cmd.flush_emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/nge_dp.sv
// Datapath for the next greater element block: stack memory, counters, result register.
`default_nettype none
`include "assert_macros.svh"

module nge_dp #(
    parameter int MAX_LEN = nge_pkg::MAX_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nge_pkg::in_word_t    sample_word,
    input  nge_pkg::nge_cmd_t    cmd,
    output nge_pkg::nge_status_t status,
    output logic                 result_valid,
    input  logic                 result_stall,
    output nge_pkg::out_word_t   result_word
);

    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ENTRY_W = $bits(nge_pkg::stack_entry_t);

    logic signed [nge_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                last_reg;
    logic                                ovf_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    next_pos_reg;
    logic                                out_valid_reg;
    nge_pkg::out_word_t                  out_word_reg;

    logic [CNT_W-1:0]       count_dec;
    logic [ENTRY_W-1:0]     rd_data;
    nge_pkg::stack_entry_t  top_entry;
    nge_pkg::stack_entry_t  push_entry;
    logic                   out_free;

    assign count_dec = count_reg - CNT_W'(1);
    assign top_entry = nge_pkg::stack_entry_t'(rd_data);
    assign out_free  = !out_valid_reg || !result_stall;

    assign push_entry.position = nge_pkg::POS_W'(next_pos_reg);
    assign push_entry.value    = sample_reg;

    // Stack storage: pushed at the count, read just below it.
    nge_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEN)
    ) u_stack (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (push_entry),
        .rd_en   (cmd.rd_issue),
        .rd_addr (count_dec[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Status for the controller.
    always_comb
    begin
        status.seq_full    = next_pos_reg >= CNT_W'(MAX_LEN);
        status.stack_empty = count_reg == '0;
        status.count_one   = count_reg == CNT_W'(1);
        status.greater     = $signed(sample_reg) > $signed(top_entry.value);
        status.last        = last_reg;
        status.out_free    = out_free;
    end

    // Captured input word.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sample_reg <= sample_word.sample_value;
            last_reg   <= sample_word.final_item;
            ovf_reg    <= status.seq_full;
        end
    end

    // Stack depth and sequence position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            next_pos_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                count_reg    <= count_reg + CNT_W'(1);
                next_pos_reg <= next_pos_reg + CNT_W'(1);
            end
            else if (cmd.pop_emit || cmd.flush_emit)
            begin
                count_reg <= count_dec;
            end
            if (cmd.flush_emit && status.count_one)
            begin
                next_pos_reg <= '0;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pop_emit || cmd.flush_emit || cmd.ovf_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        priority if (cmd.pop_emit)
        begin
            out_word_reg.position      <= top_entry.position;
            out_word_reg.greater_value <= sample_reg;
            out_word_reg.found         <= 1'b1;
            out_word_reg.overflow      <= 1'b0;
            out_word_reg.run_end       <= 1'b0;
        end
        else if (cmd.flush_emit)
        begin
            out_word_reg.position      <= top_entry.position;
            out_word_reg.greater_value <= '0;
            out_word_reg.found         <= 1'b0;
            out_word_reg.overflow      <= ovf_reg;
            out_word_reg.run_end       <= status.count_one;
        end
        else if (cmd.ovf_emit)
        begin
            out_word_reg.position      <= '0;
            out_word_reg.greater_value <= '0;
            out_word_reg.found         <= 1'b0;
            out_word_reg.overflow      <= 1'b1;
            out_word_reg.run_end       <= 1'b0;
        end
        else
        begin
            out_word_reg <= out_word_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // The stack never holds more entries than positions handed out.
    `ASSERT_NEVER(a_count_le_pos, clk, rst_n, count_reg > next_pos_reg)
    // The stack never grows past its storage.
    `ASSERT_NEVER(a_count_le_max, clk, rst_n, count_reg > CNT_W'(MAX_LEN))
    // A stack read is only issued when an entry is there.
    `ASSERT_NEVER(a_rd_nonempty, clk, rst_n, cmd.rd_issue && (count_reg == '0))
    // A new result never overwrites one that is still waiting.
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n,
        (cmd.pop_emit || cmd.flush_emit || cmd.ovf_emit) && !out_free)

endmodule

`default_nettype wire

>>> design/next_greater_element_top.sv
// Top level of the streaming next greater element block.
`default_nettype none

// Streams a sequence of signed 32-bit values and, for each position, reports
// the first later value that is strictly greater, using a stack of pending
// positions held in a single-port-read RAM of MAX_LEN entries. Results come
// out in the order they are resolved, so the position field tells which
// element each word answers; a word with final_item set flushes the stack
// with found 0, and the last word of the flush carries run_end. An item
// beyond MAX_LEN is dropped; a non-final one is answered by one overflow
// word, and a final one flushes the stack with overflow set. Each entry
// popped or flushed is a step of the stack RAM's registered read followed
// by the compare or emit, and each emit waits while output stall holds a
// waiting result. The input is taken whenever the block is between items,
// even while an earlier result waits in the output register; output stall
// holds the block only when a new result must be written. No clearing pass
// is needed after reset: the stack is only read below its fill count.
module next_greater_element_top #(
    parameter int MAX_LEN = nge_pkg::MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  nge_pkg::in_word_t  sample_word,
    output logic               result_valid,
    input  logic               result_stall,
    output nge_pkg::out_word_t result_word
);

    nge_pkg::nge_cmd_t    cmd;
    nge_pkg::nge_status_t status;

    // Sequencer.
    nge_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_final (sample_word.final_item),
        .status       (status),
        .cmd          (cmd),
        .sample_stall (sample_stall)
    );

    // Stack, counters and result register.
    nge_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_word  (sample_word),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire
